@@ src/srd_pkg.sv @@
// ----------------------------------------------------------------------------
// srd_pkg
// Types and constants shared by the descending record sorter.
// ----------------------------------------------------------------------------
package srd_pkg;

    localparam int SRD_CAPACITY    = 64;
    localparam int SRD_QUEUE_DEPTH = 4;
    localparam int KEY_W           = 32;
    localparam int TAG_W           = 6;

    localparam logic [KEY_W-1:0] KEY_SIGN = {1'b1, {(KEY_W-1){1'b0}}};

    typedef struct packed {
        logic signed [KEY_W-1:0] sort_key;
        logic [TAG_W-1:0]        record_tag;
        logic                    batch_end;
    } t_in_item;

    typedef struct packed {
        logic signed [KEY_W-1:0] out_key;
        logic [TAG_W-1:0]        out_tag;
        logic                    out_last;
        logic                    overflowed;
    } t_out_item;

    // key kept as an unsigned rank so that plain compares order it
    typedef struct packed {
        logic [KEY_W-1:0] key_rank;
        logic [TAG_W-1:0] tag;
        logic             batch_end;
    } t_queue_entry;

    typedef struct packed {
        logic         valid;
        t_queue_entry entry;
    } t_queue_head;

    typedef enum logic {
        ST_LOAD,
        ST_DRAIN
    } t_back_state;

endpackage

@@ src/srd_front.sv @@
// ----------------------------------------------------------------------------
// srd_front
// Accepts items, maps each key to an unsigned rank and queues them for the
// sorting back end.
// ----------------------------------------------------------------------------
module srd_front import srd_pkg::*; #(
    parameter int QUEUE_DEPTH = SRD_QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    output logic        o_full,
    input  t_in_item    i_item,
    output t_queue_head o_head,
    input  logic        i_head_pop
);

    localparam int AW = $clog2(QUEUE_DEPTH);

    t_queue_entry   r_mem [QUEUE_DEPTH];
    logic [AW:0]    r_wr_ptr;
    logic [AW:0]    r_rd_ptr;
    logic           push_ok;
    logic           pop_ok;
    logic           empty;
    t_queue_entry   new_entry;

    assign o_full  = (r_wr_ptr[AW] != r_rd_ptr[AW]) && (r_wr_ptr[AW-1:0] == r_rd_ptr[AW-1:0]);
    assign empty   = (r_wr_ptr == r_rd_ptr);
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_head_pop && !empty;

    always_comb begin
        new_entry.key_rank  = i_item.sort_key ^ KEY_SIGN;
        new_entry.tag       = i_item.record_tag;
        new_entry.batch_end = i_item.batch_end;
    end

    assign o_head.valid = !empty;
    assign o_head.entry = r_mem[r_rd_ptr[AW-1:0]];

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr_ptr[AW-1:0]] <= new_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
        end else begin
            if (push_ok) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop_ok) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

endmodule

@@ src/srd_back.sv @@
// ----------------------------------------------------------------------------
// srd_back
// Insertion chain that keeps the batch in descending key order, then shifts
// the batch out through an output register once the batch is closed.
// ----------------------------------------------------------------------------
module srd_back import srd_pkg::*; #(
    parameter int CAPACITY = SRD_CAPACITY
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_queue_head i_head,
    output logic        o_head_pop,
    output logic        o_empty,
    input  logic        i_pop,
    output t_out_item   o_item
);

    localparam int FW = $clog2(CAPACITY + 1);

    t_back_state      r_state;
    t_back_state      n_state;
    logic [KEY_W-1:0] r_rank [CAPACITY];
    logic [TAG_W-1:0] r_tag  [CAPACITY];
    logic [FW-1:0]    r_fill;
    logic [FW-1:0]    n_fill;
    logic [FW-1:0]    r_left;
    logic [FW-1:0]    n_left;
    logic             r_drop;
    logic             n_drop;
    logic             r_out_valid;
    t_out_item        r_out;
    logic             ins;
    logic             drain_adv;
    logic [FW-1:0]    fill_after;
    logic [CAPACITY-1:0] behind;

    assign o_head_pop = (r_state == ST_LOAD) && i_head.valid;
    assign ins        = o_head_pop && (r_fill < FW'(CAPACITY));
    assign drain_adv  = (r_state == ST_DRAIN) && (!r_out_valid || i_pop);
    assign fill_after = r_fill + FW'(ins);

    // a cell is passed over when it is empty or holds a strictly smaller key
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        assign behind[i] = (FW'(i) >= r_fill) || (i_head.entry.key_rank > r_rank[i]);

        always_ff @(posedge i_clk) begin
            if (ins) begin
                if (behind[i]) begin
                    if (i == 0) begin
                        r_rank[i] <= i_head.entry.key_rank;
                        r_tag[i]  <= i_head.entry.tag;
                    end else if (!behind[(i > 0) ? i - 1 : 0]) begin
                        r_rank[i] <= i_head.entry.key_rank;
                        r_tag[i]  <= i_head.entry.tag;
                    end else begin
                        r_rank[i] <= r_rank[(i > 0) ? i - 1 : 0];
                        r_tag[i]  <= r_tag[(i > 0) ? i - 1 : 0];
                    end
                end
            end else if (drain_adv && (i < CAPACITY - 1)) begin
                r_rank[i] <= r_rank[(i < CAPACITY - 1) ? i + 1 : i];
                r_tag[i]  <= r_tag[(i < CAPACITY - 1) ? i + 1 : i];
            end
        end
    end

    always_comb begin
        n_state = r_state;
        n_fill  = r_fill;
        n_left  = r_left;
        n_drop  = r_drop;
        case (r_state)
            ST_LOAD: begin
                if (o_head_pop) begin
                    n_fill = fill_after;
                    n_drop = r_drop | !ins;
                    if (i_head.entry.batch_end) begin
                        n_left  = fill_after;
                        n_state = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN: begin
                if (drain_adv) begin
                    n_left = r_left - 1'b1;
                    if (r_left == FW'(1)) begin
                        n_fill  = '0;
                        n_drop  = 1'b0;
                        n_state = ST_LOAD;
                    end
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_LOAD;
            r_fill      <= '0;
            r_left      <= '0;
            r_drop      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_left  <= n_left;
            r_drop  <= n_drop;
            if (drain_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (drain_adv) begin
            r_out.out_key    <= r_rank[0] ^ KEY_SIGN;
            r_out.out_tag    <= r_tag[0];
            r_out.out_last   <= (r_left == FW'(1));
            r_out.overflowed <= r_drop;
        end
    end

    assign o_empty = !r_out_valid;
    assign o_item  = r_out;

endmodule

@@ src/sort_records_descending_unit.sv @@
// ----------------------------------------------------------------------------
// sort_records_descending_unit
// Batch sorter: emits stored records in descending key order, ties in
// arrival order.
// ----------------------------------------------------------------------------
// Usage:
//   Input queue side: drive i_item and raise i_push; the item is taken on a
//   clock edge where o_full is low. The item with batch_end set closes the
//   batch. Up to CAPACITY records are kept per batch; later ones are dropped
//   and every result of that batch then shows overflowed.
//   Result queue side: while o_empty is low, o_item holds the oldest result;
//   raise i_pop to take it. out_last marks the final record of the batch.
// Throughput:
//   While loading, the insertion chain takes one item per cycle. Once the
//   closing item is accepted, the back end drains the batch of n records
//   through the output register at one result per cycle while results are
//   popped; the chain shifts once per result. During the drain new items
//   collect in the QUEUE_DEPTH entry input queue, then o_full rises.
// Reset and stalls:
//   Synchronous active-low reset empties both queues and the chain. When
//   i_pop stays low the result holds and the drain stops; loading of the
//   next batch waits until the current one has drained.
// ----------------------------------------------------------------------------
module sort_records_descending_unit import srd_pkg::*; #(
    parameter int CAPACITY    = SRD_CAPACITY,
    parameter int QUEUE_DEPTH = SRD_QUEUE_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    output logic      o_full,
    input  t_in_item  i_item,
    output logic      o_empty,
    input  logic      i_pop,
    output t_out_item o_item
);

    t_queue_head head;
    logic        head_pop;

    srd_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (i_push),
        .o_full     (o_full),
        .i_item     (i_item),
        .o_head     (head),
        .i_head_pop (head_pop)
    );

    srd_back #(
        .CAPACITY (CAPACITY)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (head),
        .o_head_pop (head_pop),
        .o_empty    (o_empty),
        .i_pop      (i_pop),
        .o_item     (o_item)
    );

endmodule

@@ src/srd_checker.sv @@
// ----------------------------------------------------------------------------
// srd_checker
// Port-level checks of the sorter's result stream, bound to the top level.
// ----------------------------------------------------------------------------
module srd_checker import srd_pkg::*; #(
    parameter int CAPACITY = SRD_CAPACITY
) (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_empty,
    input logic      i_pop,
    input t_out_item o_item
);

    localparam int FW = $clog2(CAPACITY + 1);

    logic                    r_mid;
    logic                    r_ovf;
    logic signed [KEY_W-1:0] r_prev_key;
    logic [FW-1:0]           r_cnt;
    logic                    take;

    assign take = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mid <= 1'b0;
            r_ovf <= 1'b0;
            r_cnt <= '0;
        end else if (take) begin
            r_mid <= !o_item.out_last;
            r_ovf <= o_item.overflowed;
            r_cnt <= o_item.out_last ? '0 : r_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_prev_key <= o_item.out_key;
        end
    end

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> o_empty)
        else $error("result queue not empty after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty && !i_pop |=> !o_empty && $stable(o_item))
        else $error("waiting result changed");

    a_descending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty && r_mid |-> o_item.out_key <= r_prev_key)
        else $error("results out of descending order");

    a_ovf_steady: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty && r_mid |-> o_item.overflowed == r_ovf)
        else $error("overflow flag changed within a batch");

    a_batch_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty |-> r_cnt < FW'(CAPACITY))
        else $error("batch longer than capacity");

endmodule

bind sort_records_descending_unit srd_checker #(.CAPACITY(CAPACITY)) u_srd_checker (.*);

@@ tb/sort_order_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sort_order_checker
// Watches both queue sides of the descending record sorter. Accepted input
// items go into a private insertion chain, up to SRD_CAPACITY per batch;
// when a batch closes, its records are queued in sorted order and each
// accepted result item is compared field by field with the oldest one waiting.
// ----------------------------------------------------------------------------
module sort_order_checker import srd_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  logic      i_full,
    input  t_in_item  i_in_item,
    input  logic      i_empty,
    input  logic      i_pop,
    input  t_out_item i_out_item,
    output int        o_fail_count,
    output int        o_pending
);

    logic signed [KEY_W-1:0] held_keys [SRD_CAPACITY];
    logic [TAG_W-1:0]        held_tags [SRD_CAPACITY];
    int                      held_count = 0;
    logic                    dropped    = 1'b0;
    t_out_item               sorted_results [$];
    t_out_item               want;
    int                      fail_count = 0;
    int                      pending    = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = pending;

    task automatic check_field(input string name, input logic [KEY_W-1:0] exp_val,
                               input logic [KEY_W-1:0] act_val);
        if (act_val !== exp_val) begin
            $error("%s: expected %0h, got %0h", name, exp_val, act_val);
            fail_count++;
        end
    endtask

    task automatic absorb_record(input t_in_item rec);
        int        pos;
        t_out_item res;
        if (held_count < SRD_CAPACITY) begin
            pos = held_count;
            // records with a strictly smaller key move down one place
            while (pos > 0 && $signed(held_keys[pos-1]) < $signed(rec.sort_key)) begin
                held_keys[pos] = held_keys[pos-1];
                held_tags[pos] = held_tags[pos-1];
                pos--;
            end
            held_keys[pos] = rec.sort_key;
            held_tags[pos] = rec.record_tag;
            held_count++;
        end else begin
            dropped = 1'b1;
        end
        if (rec.batch_end) begin
            for (int i = 0; i < held_count; i++) begin
                res.out_key    = held_keys[i];
                res.out_tag    = held_tags[i];
                res.out_last   = (i == held_count - 1);
                res.overflowed = dropped;
                sorted_results.push_back(res);
            end
            held_count = 0;
            dropped    = 1'b0;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            held_count = 0;
            dropped    = 1'b0;
            sorted_results.delete();
        end else begin
            if (i_pop && !i_empty) begin
                if (sorted_results.size() == 0) begin
                    $error("unexpected result item: key %0h tag %0h",
                           i_out_item.out_key, i_out_item.out_tag);
                    fail_count++;
                end else begin
                    want = sorted_results.pop_front();
                    check_field("out_key", want.out_key, i_out_item.out_key);
                    check_field("out_tag", KEY_W'(want.out_tag), KEY_W'(i_out_item.out_tag));
                    check_field("out_last", KEY_W'(want.out_last),
                                KEY_W'(i_out_item.out_last));
                    check_field("overflowed", KEY_W'(want.overflowed),
                                KEY_W'(i_out_item.overflowed));
                end
            end
            if (i_push && !i_full) begin
                absorb_record(i_in_item);
            end
        end
        pending = sorted_results.size();
    end

endmodule

@@ tb/sort_records_descending_unit_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sort_records_descending_unit_test
// Drives batches of keyed records into the descending record sorter: a few
// hand-picked batches with extreme keys and ties, batches that fill the store
// exactly and past capacity, then random batches under three idle patterns,
// with one long result stall. A checker module predicts and compares.
// ----------------------------------------------------------------------------
module sort_records_descending_unit_test;
    import srd_pkg::*;

    localparam int               TOTAL_ITEMS     = 460;
    localparam int               CYCLE_LIMIT     = 200000;
    localparam int               POP_HOLD_CYCLES = 300;
    localparam int               SETTLE_CYCLES   = 20;
    localparam logic [KEY_W-1:0] KEY_MIN         = KEY_SIGN;
    localparam logic [KEY_W-1:0] KEY_MAX         = ~KEY_SIGN;

    logic      i_clk;
    logic      i_rst_n = 1'b0;
    logic      i_push  = 1'b0;
    logic      o_full;
    t_in_item  i_item  = '0;
    logic      o_empty;
    logic      i_pop   = 1'b0;
    t_out_item o_item;

    int fail_count;
    int pending;
    int send_idle_pct = 33;
    int recv_idle_pct = 55;
    int items_sent    = 0;
    int pop_hold_req  = 0;
    int pop_hold_done = 0;
    int cycle_count   = 0;

    sort_records_descending_unit i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .o_full  (o_full),
        .i_item  (i_item),
        .o_empty (o_empty),
        .i_pop   (i_pop),
        .o_item  (o_item)
    );

    sort_order_checker u_sort_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (i_push),
        .i_full       (o_full),
        .i_in_item    (i_item),
        .i_empty      (o_empty),
        .i_pop        (i_pop),
        .i_out_item   (o_item),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // result side: random pops, or a long hold-off when asked
    initial begin
        forever begin
            @(negedge i_clk);
            if (pop_hold_req != pop_hold_done) begin
                i_pop <= 1'b0;
                repeat (POP_HOLD_CYCLES) @(negedge i_clk);
                pop_hold_done++;
            end else begin
                i_pop <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    function automatic logic [KEY_W-1:0] pick_key();
        case ($urandom_range(9))
            0:       return KEY_MAX;
            1:       return KEY_MIN;
            2, 3, 4: return KEY_W'($urandom_range(8)) - KEY_W'(4);
            default: return $urandom();
        endcase
    endfunction

    function automatic int pick_batch_len();
        if ($urandom_range(99) < 6) begin
            case ($urandom_range(4))
                0:       return SRD_CAPACITY - 1;
                1:       return SRD_CAPACITY;
                2:       return SRD_CAPACITY + 1;
                3:       return SRD_CAPACITY + 2;
                default: return SRD_CAPACITY + 6;
            endcase
        end
        return $urandom_range(12, 1);
    endfunction

    task automatic send_record(input logic [KEY_W-1:0] key, input logic [TAG_W-1:0] tag,
                               input logic last);
        t_in_item rec;
        rec.sort_key   = key;
        rec.record_tag = tag;
        rec.batch_end  = last;
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_push <= 1'b0;
            @(negedge i_clk);
        end
        i_push <= 1'b1;
        i_item <= rec;
        do @(posedge i_clk); while (o_full);
        items_sent++;
    endtask

    task automatic send_batch(input int len);
        for (int i = 0; i < len; i++) begin
            send_record(pick_key(), TAG_W'($urandom_range(63)), i == len - 1);
        end
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_push <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // single record batch
        send_record(KEY_MAX, 6'd63, 1'b1);
        // extremes, ties and mixed signs
        send_record(32'd0, 6'd1, 1'b0);
        send_record(32'hFFFF_FFFF, 6'd2, 1'b0);
        send_record(KEY_MAX, 6'd3, 1'b0);
        send_record(KEY_MIN, 6'd4, 1'b0);
        send_record(32'd5, 6'd5, 1'b0);
        send_record(32'd5, 6'd6, 1'b0);
        send_record(32'd5, 6'd7, 1'b0);
        send_record(32'hFFFF_FFFF, 6'd8, 1'b0);
        send_record(KEY_MIN, 6'd9, 1'b0);
        send_record(KEY_MAX, 6'd0, 1'b1);
        // ascending arrival
        send_record(32'd1, 6'd10, 1'b0);
        send_record(32'd2, 6'd11, 1'b0);
        send_record(32'd3, 6'd12, 1'b0);
        send_record(32'd4, 6'd13, 1'b0);
        send_record(32'd2, 6'd0, 1'b1);
        // equal minimum keys
        send_record(KEY_MIN, 6'd63, 1'b0);
        send_record(KEY_MIN, 6'd42, 1'b1);

        // exact fill, then overflow where the closing item is dropped
        send_batch(SRD_CAPACITY);
        send_batch(SRD_CAPACITY + 1);
        while (items_sent < TOTAL_ITEMS / 3) send_batch(pick_batch_len());
        wait_drained();

        send_idle_pct = 55;
        recv_idle_pct = 33;
        pop_hold_req++;
        while (items_sent < 2 * TOTAL_ITEMS / 3) send_batch(pick_batch_len());
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        while (items_sent < TOTAL_ITEMS) send_batch(pick_batch_len());
        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge i_clk);

        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
